// File: design/wlsf_pkg.sv
// Package for the wrapped line start finder: field widths, register reset
// values, register index codes and the controller/datapath handshake structs.
// No dependencies.
package wlsf_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned LINE_W   = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // Default text length limit for the byte counter.
    localparam int unsigned DEF_MAX_TEXT_LENGTH = 65535;

    // Register reset values.
    localparam logic [7:0]  RST_LINE_WIDTH  = 8'd79;
    localparam logic [7:0]  RST_TAB_WIDTH   = 8'd4;
    localparam logic        RST_WORD_WRAP   = 1'b1;
    localparam logic [15:0] RST_TARGET_LINE = 16'd1;

    // Line width sanitizing limits.
    localparam logic [7:0] WIDTH_MIN  = 8'd4;
    localparam logic [7:0] WIDTH_MAX  = 8'd254;
    localparam logic [7:0] WIDTH_DFLT = 8'd79;

    // Character codes with special meaning.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Remainder unit: one quotient bit per step over the 9-bit column.
    localparam int unsigned DIV_STEPS = 9;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH  = 8'd0,
        CFG_TAB_WIDTH   = 8'd1,
        CFG_WORD_WRAP   = 8'd2,
        CFG_TARGET_LINE = 8'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted byte and seed the remainder unit
        logic div_step;  // run one remainder step
        logic apply;     // apply the byte to the line state
        logic emit;      // load the result register and clear the text state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tab;    // captured byte is a tab
        logic is_last;   // captured byte ends the text
        logic div_done;  // the final remainder step is running
        logic out_free;  // the result register can take a new result
    } t_status;

endpackage

// File: design/wlsf_intf.sv
// Channel interfaces of the wrapped line start finder: input bytes, results
// and configuration writes. Depends on wlsf_pkg.
interface wlsf_in_if import wlsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface wlsf_out_if import wlsf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] start_position;
    logic             line_found;

    modport source (output valid, output start_position, output line_found, input ready);
    modport sink   (input valid, input start_position, input line_found, output ready);
endinterface

interface wlsf_cfg_if import wlsf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/wrapped_line_start_finder_top.sv
// Top level of the wrapped line start finder: channel interfaces, controller
// and datapath. Depends on wlsf_pkg, wlsf_intf, wlsf_ctrl and wlsf_dp.

// Text bytes arrive one per transfer on the input channel and are laid into
// display lines of the configured width; on the byte marked last the block
// delivers one result with the 1-based start of the target line, or the text
// length with line_found low. One byte is worked at a time: an ordinary byte
// goes from capture straight to the line update, while a tab first needs the
// column modulo the tab spacing for its tab stop, from a 9-step restoring
// remainder unit, one bit per cycle. After the last byte the result register
// is loaded once it is free, and it can still hold an earlier result
// while the next byte is taken in. Configuration writes are accepted in any
// cycle and must only be made while no text byte is being worked.
module wrapped_line_start_finder_top import wlsf_pkg::*; #(
    parameter int unsigned MAX_TEXT_LENGTH = DEF_MAX_TEXT_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlsf_cfg_if.sink    i_cfg,
    wlsf_in_if.sink     i_in,
    wlsf_out_if.source  o_out
);

    t_cmd    cmd;
    t_status status;

    wlsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wlsf_dp #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg.valid),
        .o_cfg_ready      (i_cfg.ready),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_text_byte      (i_in.text_byte),
        .i_is_last        (i_in.is_last),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_start_position (o_out.start_position),
        .o_line_found     (o_out.line_found),
        .i_cmd            (cmd),
        .o_status         (status)
    );

endmodule

// File: design/wlsf_ctrl.sv
// Controller of the wrapped line start finder: sequences capture, remainder
// steps, line update and result hand-off. Depends on wlsf_pkg.
module wlsf_ctrl import wlsf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_STEP = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                // Non-tab bytes skip the remainder unit.
                if (!i_status.is_tab) begin
                    n_state = S_STEP;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_done) begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                o_cmd.apply = 1'b1;
                n_state     = i_status.is_last ? S_WAIT : S_IDLE;
            end
            S_WAIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // The line update follows the last remainder step directly.
    a_div_to_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.is_tab && i_status.div_done) |=> (r_state == S_STEP))
        else $error("remainder unit did not hand over to the line update");

    // A result is only loaded when the result register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded while previous result still pending");
`endif

endmodule

// File: design/wlsf_dp.sv
// Datapath of the wrapped line start finder: configuration registers, the
// column remainder unit, the line state and the result register.
// Depends on wlsf_pkg.
module wlsf_dp import wlsf_pkg::*; #(
    parameter int unsigned MAX_TEXT_LENGTH = DEF_MAX_TEXT_LENGTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input byte.
    input  logic [BYTE_W-1:0]     i_text_byte,
    input  logic                  i_is_last,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [POS_W-1:0]      o_start_position,
    output logic                  o_line_found,
    // Controller link.
    input  t_cmd                  i_cmd,
    output t_status               o_status
);

    localparam int unsigned BW = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int unsigned PW = (BW + 1 > POS_W) ? BW + 1 : POS_W + 1;
    localparam logic [BW-1:0]   BC_MAX   = BW'(MAX_TEXT_LENGTH);
    localparam logic [PW-1:0]   POS_SAT  = PW'({POS_W{1'b1}});
    localparam logic [LINE_W-1:0] LC_MAX = {LINE_W{1'b1}};

    // Configuration registers.
    logic [7:0]        r_line_width;
    logic [7:0]        r_tab_width;
    logic              r_word_wrap;
    logic [LINE_W-1:0] r_target_line;

    // Captured byte.
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // Remainder unit.
    logic [7:0]           r_rem;
    logic [8:0]           r_dvd;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Line state. The column can sit past the width after a carried-over wrap.
    logic [8:0]        r_column;
    logic [7:0]        r_last_space;
    logic [LINE_W-1:0] r_line_count;
    logic [BW-1:0]     r_byte_count;
    logic              r_found;
    logic [POS_W-1:0]  r_found_pos;

    // Result register.
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_found;

    // Combinational values.
    logic [7:0]        w_eff;
    logic [7:0]        t_eff;
    logic [8:0]        rem_shift;
    logic              rem_ge;
    logic [9:0]        col1;
    logic [9:0]        ls1;
    logic              wrap;
    logic [9:0]        col2;
    logic              lstart;
    logic              first_hit;
    logic              found0;
    logic [BW-1:0]     bc1;
    logic [LINE_W-1:0] lc1;
    logic              line_hit;
    logic [PW-1:0]     pos_next;
    logic [PW-1:0]     pos_diff;
    logic [PW-1:0]     bc_ext;

    assign o_cfg_ready = 1'b1;

    // Sanitized width and tab spacing.
    always_comb begin
        w_eff = r_line_width;
        if (r_line_width < WIDTH_MIN || r_line_width > WIDTH_MAX) begin
            w_eff = WIDTH_DFLT;
        end
        t_eff = (r_tab_width == 8'd0) ? 8'd1 : r_tab_width;
        if (t_eff > w_eff) begin
            t_eff = w_eff - 8'd1;
        end
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width  <= RST_LINE_WIDTH;
            r_tab_width   <= RST_TAB_WIDTH;
            r_word_wrap   <= RST_WORD_WRAP;
            r_target_line <= RST_TARGET_LINE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH:  r_line_width  <= i_cfg_data[7:0];
                CFG_TAB_WIDTH:   r_tab_width   <= i_cfg_data[7:0];
                CFG_WORD_WRAP:   r_word_wrap   <= i_cfg_data[0];
                CFG_TARGET_LINE: r_target_line <= i_cfg_data[LINE_W-1:0];
                default: ;
            endcase
        end
    end

    // One restoring step of column modulo tab spacing.
    assign rem_shift = {r_rem, r_dvd[8]};
    assign rem_ge    = (rem_shift >= {1'b0, t_eff});

    // Capture register and remainder unit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte    <= i_text_byte;
            r_last    <= i_is_last;
            r_rem     <= 8'd0;
            r_dvd     <= r_column;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? 8'(rem_shift - {1'b0, t_eff}) : rem_shift[7:0];
            r_dvd     <= {r_dvd[7:0], 1'b0};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // Column and line update for the captured byte.
    always_comb begin
        col1   = {1'b0, r_column};
        ls1    = {2'b0, r_last_space};
        lstart = 1'b0;
        case (r_byte)
            CH_TAB: begin
                col1 = {1'b0, r_column} - {2'b0, r_rem} + {2'b0, t_eff};
            end
            CH_LF: begin
                col1   = 10'd0;
                ls1    = 10'd0;
                lstart = 1'b1;
            end
            CH_CR: begin
                col1 = {1'b0, r_column};
            end
            CH_SPACE: begin
                col1 = {1'b0, r_column} + 10'd1;
                ls1  = col1;
            end
            default: begin
                col1 = {1'b0, r_column} + 10'd1;
            end
        endcase

        // Wrap when the column runs past the width.
        wrap = (col1 > {2'b0, w_eff});
        col2 = col1;
        if (wrap) begin
            col2   = (r_word_wrap && ls1 != 10'd0) ? col1 - ls1 : 10'd1;
            ls1    = 10'd0;
            lstart = 1'b1;
        end

        // Target line one begins with the first byte.
        first_hit = (r_byte_count == '0) && !r_found && (r_target_line == LINE_W'(1));
        found0    = r_found || first_hit;

        bc1 = (r_byte_count < BC_MAX) ? r_byte_count + BW'(1) : r_byte_count;
        lc1 = r_line_count;
        if (lstart && r_line_count < LC_MAX) begin
            lc1 = r_line_count + LINE_W'(1);
        end
        line_hit = lstart && !found0 && (lc1 == r_target_line);

        // Start of the new line, clamped at 1 and saturated to the field.
        pos_next = PW'(bc1) + PW'(1);
        pos_diff = (pos_next > PW'(col2)) ? pos_next - PW'(col2) : PW'(1);
        if (pos_diff > POS_SAT) begin
            pos_diff = POS_SAT;
        end
        bc_ext = PW'(r_byte_count);
        if (bc_ext > POS_SAT) begin
            bc_ext = POS_SAT;
        end
    end

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_column     <= 9'd0;
            r_last_space <= 8'd0;
            r_line_count <= LINE_W'(1);
            r_byte_count <= '0;
            r_found      <= 1'b0;
            r_found_pos  <= '0;
        end else if (i_cmd.apply) begin
            r_column     <= col2[8:0];
            r_last_space <= ls1[7:0];
            r_line_count <= lc1;
            r_byte_count <= bc1;
            r_found      <= found0 || line_hit;
            if (first_hit) begin
                r_found_pos <= POS_W'(1);
            end else if (line_hit) begin
                r_found_pos <= pos_diff[POS_W-1:0];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pos   <= r_found ? r_found_pos : bc_ext[POS_W-1:0];
            r_out_found <= r_found;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_start_position = r_out_pos;
    assign o_line_found     = r_out_found;

    assign o_status.is_tab   = (r_byte == CH_TAB);
    assign o_status.is_last  = r_last;
    assign o_status.div_done = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

`ifndef NO_ASSERTIONS
    // A latched start position is always a valid 1-based position.
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_found_pos != '0))
        else $error("latched start position is zero");

    // Handing off a result restarts the text.
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_byte_count == '0 && r_line_count == LINE_W'(1) && !r_found))
        else $error("text state not cleared after result");

    // The tab remainder is below the tab spacing when it is used.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_byte == CH_TAB) |-> (r_rem < t_eff))
        else $error("tab remainder out of range");
`endif

endmodule

// File: tb/tb_wrapped_line_start_finder_top.sv
// Self-checking testbench for the wrapped line start finder top level.
// Depends on wlsf_pkg, the wlsf channel interfaces and wrapped_line_start_finder_top.
`timescale 1ns / 100ps

module tb_wrapped_line_start_finder_top;
    import wlsf_pkg::*;

    localparam int unsigned TEXT_LIMIT   = DEF_MAX_TEXT_LENGTH;
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned LONG_LEN     = 200;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } line_start_t;

    logic i_clk;
    logic i_rst_n;

    wlsf_in_if  in_ch ();
    wlsf_out_if out_ch ();
    wlsf_cfg_if cfg_ch ();

    wrapped_line_start_finder_top #(
        .MAX_TEXT_LENGTH (TEXT_LIMIT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Copies of the configuration registers as last written.
    logic [7:0]        cur_line_width;
    logic [7:0]        cur_tab_width;
    logic              cur_word_wrap;
    logic [LINE_W-1:0] cur_target_line;

    // Line layout state of the text in progress.
    int unsigned       col;
    int unsigned       space_col;
    logic [LINE_W-1:0] line_cnt;
    logic [POS_W-1:0]  byte_cnt;
    logic              found_flag;
    logic [POS_W:0]    found_pos;

    // Expected line starts, oldest first.
    line_start_t start_q[$];

    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;
    bit          hold_req   = 1'b0;
    bit          gaps_on;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Long result hold-off, loaded on request and counted down on its own.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result ready with random stall bursts and the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        err_cnt++;
    endtask

    // Each result transfer is compared with the oldest expected line start.
    always @(posedge i_clk) begin : check_results
        line_start_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (start_q.size() == 0) begin
                report_mismatch("unexpected result", 0, out_ch.start_position);
            end else begin
                want = start_q.pop_front();
                if (out_ch.start_position !== want.position) begin
                    report_mismatch("start_position", want.position, out_ch.start_position);
                end
                if (out_ch.line_found !== want.found) begin
                    report_mismatch("line_found", want.found, out_ch.line_found);
                end
            end
        end
    end

    function automatic void clear_text();
        col        = 0;
        space_col  = 0;
        line_cnt   = LINE_W'(1);
        byte_cnt   = '0;
        found_flag = 1'b0;
        found_pos  = '0;
    endfunction

    // Lays one accepted byte into the lines and queues the result on the last byte.
    function automatic void predict_line_start(input logic [7:0] ch, input logic last);
        int unsigned w;
        int unsigned t;
        int unsigned pos;
        bit          new_line;
        line_start_t res;
        w = cur_line_width;
        t = cur_tab_width;
        new_line = 1'b0;
        if (w < WIDTH_MIN || w > WIDTH_MAX) w = WIDTH_DFLT;
        if (t == 0) t = 1;
        if (t > w) t = w - 1;

        // Line one starts with the first byte.
        if (byte_cnt == 0 && !found_flag && cur_target_line == 1) begin
            found_flag = 1'b1;
            found_pos  = (POS_W+1)'(1);
        end
        if (byte_cnt < TEXT_LIMIT) byte_cnt++;

        case (ch)
            CH_TAB: col = (col / t) * t + t;
            CH_LF: begin
                col       = 0;
                space_col = 0;
                new_line  = 1'b1;
            end
            CH_CR: ;
            CH_SPACE: begin
                col++;
                space_col = col;
            end
            default: col++;
        endcase

        // Wrap past the width, carrying the word after the last space if allowed.
        if (col > w) begin
            if (cur_word_wrap && space_col != 0) col = col - space_col;
            else col = 1;
            space_col = 0;
            new_line  = 1'b1;
        end

        if (new_line) begin
            if (line_cnt != 16'hFFFF) line_cnt++;
            if (!found_flag && line_cnt == cur_target_line) begin
                pos        = byte_cnt + 1;
                found_flag = 1'b1;
                found_pos  = (pos > col) ? (POS_W+1)'(pos - col) : (POS_W+1)'(1);
            end
        end

        if (last) begin
            if (!found_flag) res.position = byte_cnt;
            else if (found_pos > 17'h0FFFF) res.position = 16'hFFFF;
            else res.position = found_pos[POS_W-1:0];
            res.found = found_flag;
            start_q.push_back(res);
            clear_text();
        end
    endfunction

    // Offers one byte, with an occasional gap in front, and predicts on the transfer.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= ch;
        in_ch.is_last   <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_line_start(ch, last);
    endtask

    task automatic send_bytes(input logic [7:0] txt[$], input bit ends_text);
        foreach (txt[i]) begin
            send_byte(txt[i], ends_text && i == txt.size() - 1);
        end
    endtask

    // Drops valid, waits for every expected result, then lets the block go idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (start_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH:  cur_line_width  = value[7:0];
            CFG_TAB_WIDTH:   cur_tab_width   = value[7:0];
            CFG_WORD_WRAP:   cur_word_wrap   = value[0];
            CFG_TARGET_LINE: cur_target_line = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [7:0] w, input logic [7:0] t, input logic ww,
                               input logic [LINE_W-1:0] tl);
        settle();
        write_reg(CFG_LINE_WIDTH, {8'h00, w});
        write_reg(CFG_TAB_WIDTH, {8'h00, t});
        write_reg(CFG_WORD_WRAP, {15'h0000, ww});
        write_reg(CFG_TARGET_LINE, tl);
    endtask

    // Picks settings that mostly give narrow lines, with the extremes now and then.
    task automatic random_settings();
        logic [7:0]        w;
        logic [7:0]        t;
        logic [LINE_W-1:0] tl;
        case ($urandom_range(0, 9))
            0: w = 8'($urandom_range(0, 3));
            1: w = WIDTH_MAX;
            2: w = 8'd255;
            3: w = 8'($urandom_range(0, 255));
            default: w = 8'($urandom_range(4, 24));
        endcase
        t  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 8));
        tl = ($urandom_range(0, 4) == 0) ? LINE_W'($urandom_range(0, 65535))
                                         : LINE_W'($urandom_range(0, 6));
        reconfigure(w, t, 1'($urandom_range(0, 1)), tl);
    endtask

    // Text bytes weighted toward the characters that steer the layout.
    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: return CH_SPACE;
            6, 7:             return CH_TAB;
            8, 9:             return CH_LF;
            10:               return CH_CR;
            default:          return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_text(inout int unsigned sent);
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(random_char(), i == len - 1);
        end
        sent += len;
    endtask

    // Field extremes, every register and each special case of the line layout.
    task automatic test_directed();
        logic [7:0] txt[$];
        // Reset settings: line one starts at the first byte; byte value extremes.
        txt = {8'h00, CH_TAB, 8'hFF};
        send_bytes(txt, 1'b1);
        // A target line of zero never begins, so the text length comes back.
        reconfigure(RST_LINE_WIDTH, RST_TAB_WIDTH, 1'b1, 16'd0);
        txt = {8'h61, CH_LF};
        send_bytes(txt, 1'b1);
        // A line feed as the last byte opens line two just past the end.
        reconfigure(RST_LINE_WIDTH, RST_TAB_WIDTH, 1'b1, 16'd2);
        txt = {8'h78, CH_LF};
        send_bytes(txt, 1'b1);
        // Word wrap at the narrowest width carries the last word over.
        reconfigure(WIDTH_MIN, RST_TAB_WIDTH, 1'b1, 16'd2);
        txt = {8'h61, 8'h62, CH_SPACE, 8'h63, 8'h64};
        send_bytes(txt, 1'b1);
        // Hard break at the width with a skipped carriage return.
        reconfigure(WIDTH_MIN, RST_TAB_WIDTH, 1'b0, 16'd2);
        txt = {8'h61, 8'h62, CH_CR, 8'h63, 8'h64, 8'h65};
        send_bytes(txt, 1'b1);
        // Zero tab spacing and an out-of-range width.
        reconfigure(8'd255, 8'd0, 1'b1, 16'd3);
        txt = {CH_TAB, CH_TAB, CH_LF};
        send_bytes(txt, 1'b1);
        // Tab spacing beyond the widest line.
        reconfigure(WIDTH_MAX, 8'd255, 1'b1, 16'd2);
        txt = {CH_TAB, CH_TAB};
        send_bytes(txt, 1'b1);
        // Target line changed between two bytes of one text.
        reconfigure(8'd0, RST_TAB_WIDTH, 1'b1, 16'hFFFF);
        txt = {8'h61};
        send_bytes(txt, 1'b0);
        settle();
        write_reg(CFG_TARGET_LINE, 16'd2);
        txt = {CH_LF};
        send_bytes(txt, 1'b1);
    endtask

    // One long text of line feeds whose target line lies past its end.
    task automatic test_long_text();
        gaps_on = 1'b0;
        reconfigure(RST_LINE_WIDTH, RST_TAB_WIDTH, 1'b1, 16'hFFFF);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        for (int unsigned i = 0; i < LONG_LEN; i++) begin
            send_byte(CH_LF, i == LONG_LEN - 1);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_texts(input int unsigned goal, input bit with_gaps);
        int unsigned sent;
        sent    = 0;
        gaps_on = with_gaps;
        while (sent < goal) begin
            random_settings();
            repeat ($urandom_range(1, 4)) send_random_text(sent);
        end
    endtask

    // Results are held off for a long stretch while short texts keep coming.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        reconfigure(WIDTH_MIN, 8'd2, 1'b1, 16'd2);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (6) begin
            send_byte(random_char(), 1'b0);
            send_byte(random_char(), 1'b0);
            send_byte(random_char(), 1'b1);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.text_byte <= '0;
        in_ch.is_last   <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        cur_line_width  = RST_LINE_WIDTH;
        cur_tab_width   = RST_TAB_WIDTH;
        cur_word_wrap   = RST_WORD_WRAP;
        cur_target_line = RST_TARGET_LINE;
        clear_text();
        err_cnt = 0;
        gaps_on = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_text();
        test_random_texts(250, 1'b1);
        test_backpressure();
        test_random_texts(100, 1'b0);
        settle();

        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/wlsf_pkg.sv
design/wlsf_intf.sv
design/wlsf_ctrl.sv
design/wlsf_dp.sv
design/wrapped_line_start_finder_top.sv
tb/tb_wrapped_line_start_finder_top.sv
